FILE: hw/rtl/delimited_ascii_field_parser_unit_assert.svh
// assertion helpers used by the checker file
`ifndef DELIMITED_ASCII_FIELD_PARSER_UNIT_ASSERT_SVH
`define DELIMITED_ASCII_FIELD_PARSER_UNIT_ASSERT_SVH

// checked only while out of reset
`define DAFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define DAFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/dafp_pkg.sv
package dafp_pkg;

  localparam int OUT_DATA = 6;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // delimiter scanner phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_OPEN = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_id;
    logic [7:0] msg_type;
    logic [2:0] data_count;
    logic [7:0] data_0;
    logic [7:0] data_1;
    logic [7:0] data_2;
    logic [7:0] data_3;
    logic [7:0] data_4;
    logic [7:0] data_5;
    logic       data_overflow;
  } out_item_t;

  // per-word control from the top level to the scanners
  typedef struct packed {
    logic scan;
    logic restart;
  } scan_ctl_t;

  // control from a scanner to its converter
  typedef struct packed {
    logic clear;
    logic feed;
  } conv_ctl_t;

  typedef struct packed {
    logic [2:0]                   count;
    logic [OUT_DATA-1:0][7:0]     slot;
    logic                         overflow;
  } data_res_t;

endpackage

FILE: hw/rtl/delimited_ascii_field_parser_unit.sv
// flow: an accepted word is scanned from the input register; if marked last,
// its result goes into the result register, and it waits while out_stall
// holds a result; otherwise one word per cycle, set by the single scan stage
// reset: rst_n low at an edge empties both registers and clears all scanners
module delimited_ascii_field_parser_unit #(
  parameter int DATA_SLOTS = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dafp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dafp_pkg::out_item_t out_data
);
  import dafp_pkg::*;

  // input register
  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r;
  // a zero byte stops all scanning until the word marked last
  logic      text_ended_r, text_ended_nxt;
  // result register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;

  logic      in_take, out_free, advance, restart;
  scan_ctl_t ctl;
  logic [7:0] id_nxt, type_nxt;
  data_res_t data_nxt;

  // a word without the last mark never needs the result register
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && (!s1_item_r.last || out_free);
  assign restart  = advance && s1_item_r.last;
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    ctl.scan    = advance && !text_ended_r && (s1_item_r.char_byte != CH_NUL);
    ctl.restart = restart;
  end

  // the three scanners see every scanned byte independently
  dafp_pair u_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .ch        (s1_item_r.char_byte),
    .mark      (CH_HASH),
    .value_nxt (id_nxt)
  );

  dafp_pair u_dollar (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .ch        (s1_item_r.char_byte),
    .mark      (CH_DOLLAR),
    .value_nxt (type_nxt)
  );

  dafp_data #(
    .DATA_SLOTS (DATA_SLOTS)
  ) u_data (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .ch      (s1_item_r.char_byte),
    .res_nxt (data_nxt)
  );

  always_comb begin
    // input register: load on accept, empty once the word moves on
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end

    text_ended_nxt = text_ended_r;
    if (restart) begin
      text_ended_nxt = 1'b0;
    end else if (advance && (s1_item_r.char_byte == CH_NUL)) begin
      text_ended_nxt = 1'b1;
    end

    // result built from the scanner values after this byte
    out_nxt.frame_id      = id_nxt;
    out_nxt.msg_type      = type_nxt;
    out_nxt.data_count    = data_nxt.count;
    out_nxt.data_0        = data_nxt.slot[0];
    out_nxt.data_1        = data_nxt.slot[1];
    out_nxt.data_2        = data_nxt.slot[2];
    out_nxt.data_3        = data_nxt.slot[3];
    out_nxt.data_4        = data_nxt.slot[4];
    out_nxt.data_5        = data_nxt.slot[5];
    out_nxt.data_overflow = data_nxt.overflow;

    out_valid_nxt = out_valid_r;
    if (restart) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      text_ended_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      text_ended_r <= text_ended_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_data;
    end
    if (restart) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: hw/rtl/dafp_conv.sv
module dafp_conv (
  input  logic               clk,
  input  logic               rst_n,
  input  dafp_pkg::conv_ctl_t ctl,
  input  logic [7:0]         ch,
  output logic [7:0]         value,
  output logic               nonempty
);
  import dafp_pkg::*;

  localparam logic [1:0] STG_SKIP   = 2'd0;
  localparam logic [1:0] STG_DIGITS = 2'd1;
  localparam logic [1:0] STG_STOP   = 2'd2;

  logic [1:0] stage_r, stage_nxt;
  logic [7:0] accum_r, accum_nxt;
  logic       neg_r, neg_nxt;
  logic       nonempty_r, nonempty_nxt;
  logic       is_digit, is_ws, is_sign;
  logic [7:0] digit_val, acc_step;

  always_comb begin
    is_digit  = ch inside {[CH_ZERO:CH_NINE]};
    is_ws     = ch inside {CH_SPACE, [CH_TAB:CH_CR]};
    is_sign   = (ch == CH_PLUS) || (ch == CH_MINUS);
    digit_val = ch - CH_ZERO;
    // accum * 10 + digit, modulo 256
    acc_step  = {accum_r[4:0], 3'b000} + {accum_r[6:0], 1'b0} + digit_val;

    stage_nxt    = stage_r;
    accum_nxt    = accum_r;
    neg_nxt      = neg_r;
    nonempty_nxt = nonempty_r;

    if (ctl.clear) begin
      stage_nxt    = STG_SKIP;
      accum_nxt    = 8'd0;
      neg_nxt      = 1'b0;
      nonempty_nxt = 1'b0;
    end else if (ctl.feed) begin
      nonempty_nxt = 1'b1;
      case (stage_r)
        STG_SKIP: begin
          if (is_ws) begin
            stage_nxt = STG_SKIP;
          end else if (is_sign) begin
            neg_nxt   = (ch == CH_MINUS);
            stage_nxt = STG_DIGITS;
          end else if (is_digit) begin
            stage_nxt = STG_DIGITS;
            accum_nxt = acc_step;
          end else begin
            stage_nxt = STG_STOP;
          end
        end
        STG_DIGITS: begin
          if (is_digit) begin
            accum_nxt = acc_step;
          end else begin
            stage_nxt = STG_STOP;
          end
        end
        default: begin
          stage_nxt = stage_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r    <= STG_SKIP;
      accum_r    <= 8'd0;
      neg_r      <= 1'b0;
      nonempty_r <= 1'b0;
    end else begin
      stage_r    <= stage_nxt;
      accum_r    <= accum_nxt;
      neg_r      <= neg_nxt;
      nonempty_r <= nonempty_nxt;
    end
  end

  assign value    = neg_r ? (8'd0 - accum_r) : accum_r;
  assign nonempty = nonempty_r;

endmodule

FILE: hw/rtl/dafp_pair.sv
module dafp_pair (
  input  logic                clk,
  input  logic                rst_n,
  input  dafp_pkg::scan_ctl_t ctl,
  input  logic [7:0]          ch,
  input  logic [7:0]          mark,
  output logic [7:0]          value_nxt
);
  import dafp_pkg::*;

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] dest_r, dest_upd, dest_nxt;
  conv_ctl_t  conv_ctl;
  logic [7:0] conv_val;
  logic       conv_ne;

  dafp_conv u_conv (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (conv_ctl),
    .ch       (ch),
    .value    (conv_val),
    .nonempty (conv_ne)
  );

  always_comb begin
    conv_ctl  = '0;
    phase_nxt = phase_r;
    dest_upd  = dest_r;
    if (ctl.scan) begin
      case (phase_r)
        PH_IDLE: begin
          if (ch == mark) begin
            phase_nxt      = PH_OPEN;
            conv_ctl.clear = 1'b1;
          end
        end
        PH_OPEN: begin
          if (ch == mark) begin
            if (conv_ne) begin
              dest_upd = conv_val;
            end
            phase_nxt = PH_DONE;
          end else begin
            conv_ctl.feed = 1'b1;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
    // end of message: back to the idle values
    dest_nxt = dest_upd;
    if (ctl.restart) begin
      conv_ctl.clear = 1'b1;
      phase_nxt      = PH_IDLE;
      dest_nxt       = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      dest_r  <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      dest_r  <= dest_nxt;
    end
  end

  assign value_nxt = dest_upd;

endmodule

FILE: hw/rtl/dafp_data.sv
module dafp_data #(
  parameter int DATA_SLOTS = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dafp_pkg::scan_ctl_t ctl,
  input  logic [7:0]          ch,
  output dafp_pkg::data_res_t res_nxt
);
  import dafp_pkg::*;

  localparam int CW = $clog2(DATA_SLOTS + 1);

  logic [1:0]    phase_r, phase_nxt;
  logic [CW-1:0] count_r, count_upd, count_nxt;
  logic          ovf_r, ovf_upd, ovf_nxt;
  logic [7:0]    slot_r   [DATA_SLOTS];
  logic [7:0]    slot_upd [DATA_SLOTS];
  logic [7:0]    slot_nxt [DATA_SLOTS];
  logic [OUT_DATA-1:0][7:0] slot_out;
  logic          store;
  logic [3:0]    count_ext;
  conv_ctl_t     conv_ctl;
  logic [7:0]    conv_val;
  logic          conv_ne;

  dafp_conv u_conv (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (conv_ctl),
    .ch       (ch),
    .value    (conv_val),
    .nonempty (conv_ne)
  );

  always_comb begin
    conv_ctl  = '0;
    phase_nxt = phase_r;
    count_upd = count_r;
    ovf_upd   = ovf_r;
    store     = 1'b0;
    if (ctl.scan) begin
      case (phase_r)
        PH_IDLE: begin
          if (ch == CH_AMP) begin
            phase_nxt      = PH_OPEN;
            conv_ctl.clear = 1'b1;
          end
        end
        PH_OPEN: begin
          if (ch == CH_AMP) begin
            if (!conv_ne) begin
              phase_nxt = PH_DONE;
            end else if (count_r < CW'(DATA_SLOTS)) begin
              store          = 1'b1;
              count_upd      = count_r + CW'(1);
              conv_ctl.clear = 1'b1;
            end else begin
              ovf_upd   = 1'b1;
              phase_nxt = PH_DONE;
            end
          end else begin
            conv_ctl.feed = 1'b1;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end

    for (int i = 0; i < DATA_SLOTS; i++) begin
      slot_upd[i] = (store && (count_r == CW'(i))) ? conv_val : slot_r[i];
      slot_nxt[i] = ctl.restart ? 8'd0 : slot_upd[i];
    end

    count_nxt = count_upd;
    ovf_nxt   = ovf_upd;
    if (ctl.restart) begin
      conv_ctl.clear = 1'b1;
      phase_nxt      = PH_IDLE;
      count_nxt      = '0;
      ovf_nxt        = 1'b0;
    end

    // count saturates at seven in the three-bit field
    count_ext       = 4'(count_upd);
    res_nxt.count    = (count_ext > 4'd7) ? 3'd7 : count_ext[2:0];
    res_nxt.slot     = slot_out;
    res_nxt.overflow = ovf_upd;
  end

  for (genvar j = 0; j < OUT_DATA; j++) begin : g_out
    if (j < DATA_SLOTS) begin : g_used
      assign slot_out[j] = slot_upd[j];
    end else begin : g_unused
      assign slot_out[j] = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      count_r <= '0;
      ovf_r   <= 1'b0;
      for (int i = 0; i < DATA_SLOTS; i++) begin
        slot_r[i] <= 8'd0;
      end
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      for (int i = 0; i < DATA_SLOTS; i++) begin
        slot_r[i] <= slot_nxt[i];
      end
    end
  end

endmodule

FILE: hw/rtl/dafp_checker.sv
module dafp_checker #(
  parameter int DATA_SLOTS = 6
) (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input dafp_pkg::out_item_t out_data
);
  import dafp_pkg::*;

  `include "delimited_ascii_field_parser_unit_assert.svh"

  localparam logic [2:0] CNT_FULL = (DATA_SLOTS > 7) ? 3'd7 : 3'(DATA_SLOTS);

  logic no_data;
  logic out_wait;
  logic ovf_shown;
  logic cnt_full;
  logic none_shown;
  assign no_data = (out_data.data_0 == 8'd0) && (out_data.data_1 == 8'd0) &&
                   (out_data.data_2 == 8'd0) && (out_data.data_3 == 8'd0) &&
                   (out_data.data_4 == 8'd0) && (out_data.data_5 == 8'd0);
  assign out_wait   = out_valid && out_stall;
  assign ovf_shown  = out_valid && out_data.data_overflow;
  assign cnt_full   = (out_data.data_count == CNT_FULL);
  assign none_shown = out_valid && (out_data.data_count == 3'd0);

  `DAFP_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "result shown after reset")
  `DAFP_ASSERT(a_out_hold, out_wait |=> out_valid && $stable(out_data), "result lost")
  `DAFP_ASSERT(a_ovf_full, ovf_shown |-> cnt_full, "overflow with free slots")
  `DAFP_ASSERT(a_empty_zero, none_shown |-> no_data, "data without count")

endmodule

bind delimited_ascii_field_parser_unit dafp_checker #(
  .DATA_SLOTS (DATA_SLOTS)
) u_dafp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: test/field_parser_check.sv
`timescale 1ns / 100ps

module field_parser_check #(
  parameter int DATA_SLOTS = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  dafp_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  dafp_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  results_owed
);
  import dafp_pkg::*;

  localparam int SC_ID   = 0;
  localparam int SC_TYPE = 1;
  localparam int SC_DATA = 2;

  typedef enum logic [1:0] {
    CV_SKIP   = 2'd0,
    CV_DIGITS = 2'd1,
    CV_STOP   = 2'd2
  } conv_stage_t;

  logic [1:0]  scan_phase [3];
  conv_stage_t cv_stage [3];
  logic [7:0]  cv_acc [3];
  logic        cv_neg [3];
  logic        cv_seen [3];
  logic [7:0]  id_val;
  logic [7:0]  type_val;
  logic [7:0]  slot_value [8];
  int          slots_used;
  logic        data_ovf;
  logic        text_done;
  out_item_t   parsed_q [$];
  out_item_t   oldest;
  out_item_t   frame;
  int          fails = 0;

  function automatic bit is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic void conv_clear(int k);
    cv_stage[k] = CV_SKIP;
    cv_acc[k]   = 8'd0;
    cv_neg[k]   = 1'b0;
    cv_seen[k]  = 1'b0;
  endfunction

  function automatic logic [7:0] conv_value(int k);
    return cv_neg[k] ? 8'd0 - cv_acc[k] : cv_acc[k];
  endfunction

  function automatic void conv_feed(int k, logic [7:0] c);
    cv_seen[k] = 1'b1;
    if (cv_stage[k] == CV_SKIP) begin
      if (is_space(c)) return;
      if (c == CH_PLUS || c == CH_MINUS) begin
        cv_neg[k]   = (c == CH_MINUS);
        cv_stage[k] = CV_DIGITS;
        return;
      end
      cv_stage[k] = is_digit(c) ? CV_DIGITS : CV_STOP;
    end else if (cv_stage[k] == CV_DIGITS && !is_digit(c)) begin
      cv_stage[k] = CV_STOP;
    end
    if (cv_stage[k] == CV_DIGITS && is_digit(c)) begin
      cv_acc[k] = cv_acc[k] * 8'd10 + (c - CH_ZERO);
    end
  endfunction

  function automatic void clear_parse();
    for (int k = 0; k < 3; k++) begin
      scan_phase[k] = PH_IDLE;
      conv_clear(k);
    end
    foreach (slot_value[i]) slot_value[i] = 8'd0;
    id_val     = 8'd0;
    type_val   = 8'd0;
    slots_used = 0;
    data_ovf   = 1'b0;
    text_done  = 1'b0;
  endfunction

  // id and type: only the first pair of marks counts
  function automatic void scan_pair(int k, logic [7:0] mark, logic [7:0] c);
    case (scan_phase[k])
      PH_IDLE: begin
        if (c == mark) begin
          scan_phase[k] = PH_OPEN;
          conv_clear(k);
        end
      end
      PH_OPEN: begin
        if (c != mark) begin
          conv_feed(k, c);
        end else begin
          if (cv_seen[k]) begin
            if (k == SC_ID) id_val = conv_value(k);
            else type_val = conv_value(k);
          end
          scan_phase[k] = PH_DONE;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void scan_data(logic [7:0] c);
    case (scan_phase[SC_DATA])
      PH_IDLE: begin
        if (c == CH_AMP) begin
          scan_phase[SC_DATA] = PH_OPEN;
          conv_clear(SC_DATA);
        end
      end
      PH_OPEN: begin
        if (c != CH_AMP) begin
          conv_feed(SC_DATA, c);
        end else if (!cv_seen[SC_DATA]) begin
          scan_phase[SC_DATA] = PH_DONE;
        end else if (slots_used < DATA_SLOTS) begin
          slot_value[slots_used] = conv_value(SC_DATA);
          slots_used++;
          conv_clear(SC_DATA);
        end else begin
          data_ovf = 1'b1;
          scan_phase[SC_DATA] = PH_DONE;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void parse_word(in_item_t w);
    if (!text_done) begin
      if (w.char_byte == CH_NUL) begin
        text_done = 1'b1;
      end else begin
        scan_pair(SC_ID, CH_HASH, w.char_byte);
        scan_pair(SC_TYPE, CH_DOLLAR, w.char_byte);
        scan_data(w.char_byte);
      end
    end
    if (w.last) begin
      frame.frame_id      = id_val;
      frame.msg_type      = type_val;
      frame.data_count    = (slots_used > 7) ? 3'd7 : 3'(slots_used);
      frame.data_0        = slot_value[0];
      frame.data_1        = slot_value[1];
      frame.data_2        = slot_value[2];
      frame.data_3        = slot_value[3];
      frame.data_4        = slot_value[4];
      frame.data_5        = slot_value[5];
      frame.data_overflow = data_ovf;
      parsed_q.push_back(frame);
      clear_parse();
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parse();
      parsed_q.delete();
    end else begin
      // results leaving first, the word arriving at this edge cannot be among them
      if (out_valid && !out_stall) begin
        if (parsed_q.size() == 0) begin
          fails++;
          $display("%0t: result expected none, got %h", $time, out_data);
        end else begin
          oldest = parsed_q.pop_front();
          check_field("frame_id", oldest.frame_id, out_data.frame_id);
          check_field("msg_type", oldest.msg_type, out_data.msg_type);
          check_field("data_count", oldest.data_count, out_data.data_count);
          check_field("data_0", oldest.data_0, out_data.data_0);
          check_field("data_1", oldest.data_1, out_data.data_1);
          check_field("data_2", oldest.data_2, out_data.data_2);
          check_field("data_3", oldest.data_3, out_data.data_3);
          check_field("data_4", oldest.data_4, out_data.data_4);
          check_field("data_5", oldest.data_5, out_data.data_5);
          check_field("data_overflow", oldest.data_overflow, out_data.data_overflow);
        end
      end
      if (in_valid && !in_stall) parse_word(in_data);
    end
    results_owed <= parsed_q.size();
    fail_count   <= fails;
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import dafp_pkg::*;

  localparam int SLOTS          = 6;
  localparam int RANDOM_WORDS   = 700;
  localparam int HOLDOFF_CYCLES = 200;
  localparam int QUIET_LIMIT    = 5000;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int fail_count;
  int results_owed;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_asks   = 0;
  int hold_taken  = 0;
  int hold_left   = 0;
  int quiet_cycles = 0;
  int words_sent  = 0;

  // bytes of the message being built
  logic [7:0] msg_bytes [$];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  delimited_ascii_field_parser_unit #(
    .DATA_SLOTS(SLOTS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  field_parser_check #(
    .DATA_SLOTS(SLOTS)
  ) i_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .results_owed(results_owed)
  );

  // receiver: random stalls, or a long hold-off when the stimulus asks for one
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_asks) begin
      hold_taken <= hold_asks;
      hold_left  <= HOLDOFF_CYCLES;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog on cycles in which no word moves on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one word, idling first at the current rate, and wait until it is taken
  task automatic send_word(input in_item_t w);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // the last byte of the buffer carries the last flag
  task automatic send_message();
    in_item_t w;
    for (int i = 0; i < msg_bytes.size(); i++) begin
      w.char_byte = msg_bytes[i];
      w.last      = (i == msg_bytes.size() - 1);
      send_word(w);
    end
    msg_bytes.delete();
  endtask

  // stop offering until every result owed has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick_space();
    int r;
    r = $urandom_range(5);
    return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
  endfunction

  function automatic logic [7:0] pick_letter();
    return "a" + 8'($urandom_range(25));
  endfunction

  // one numeric field: whitespace, sign, digits and trailing junk in random mixes
  function automatic void put_field(bit allow_empty);
    int kind;
    int n;
    logic [7:0] junk;
    kind = $urandom_range(allow_empty ? 0 : 1, 9);
    if (kind == 0) return;
    if (kind == 1) begin
      n = $urandom_range(1, 3);
      repeat (n) msg_bytes.push_back(pick_space());
      return;
    end
    if (kind == 2) begin
      msg_bytes.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
      return;
    end
    // junk up front stops the conversion before any digit
    if (kind == 3) msg_bytes.push_back(pick_letter());
    if ($urandom_range(1)) begin
      n = $urandom_range(1, 2);
      repeat (n) msg_bytes.push_back(pick_space());
    end
    if ($urandom_range(2) == 0) msg_bytes.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
    // now and then a long run of digits that wraps many times
    n = ($urandom_range(9) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 3);
    repeat (n) msg_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
    if ($urandom_range(4) == 0) begin
      junk = 8'($urandom_range(1, 255));
      if (junk == CH_HASH || junk == CH_DOLLAR || junk == CH_AMP) junk = "x";
      msg_bytes.push_back(junk);
    end
  endfunction

  // id or type section, sometimes left unclosed
  function automatic void put_pair(logic [7:0] mark);
    msg_bytes.push_back(mark);
    put_field(1'b1);
    if ($urandom_range(9) != 0) msg_bytes.push_back(mark);
  endfunction

  // data section: up to eight fields so the slots overflow now and then
  function automatic void put_data();
    int n;
    msg_bytes.push_back(CH_AMP);
    n = $urandom_range(8);
    repeat (n) begin
      put_field($urandom_range(29) == 0);
      msg_bytes.push_back(CH_AMP);
    end
    if ($urandom_range(3) == 0) msg_bytes.push_back(CH_AMP);
    else if ($urandom_range(5) == 0) put_field(1'b0);
  endfunction

  function automatic void build_message();
    int nsec;
    int n;
    int s;
    if ($urandom_range(9) == 0) begin
      // raw noise over the full byte range
      n = $urandom_range(1, 12);
      repeat (n) msg_bytes.push_back(8'($urandom_range(255)));
      return;
    end
    nsec = $urandom_range(1, 4);
    repeat (nsec) begin
      s = $urandom_range(2);
      if (s == 0) put_pair(CH_HASH);
      else if (s == 1) put_pair(CH_DOLLAR);
      else put_data();
      if ($urandom_range(3) == 0) msg_bytes.push_back(pick_letter());
    end
    // early terminator, anything after it must be ignored
    if ($urandom_range(6) == 0) begin
      msg_bytes.push_back(CH_NUL);
      n = $urandom_range(3);
      repeat (n) msg_bytes.push_back(8'($urandom_range(255)));
    end
    if (msg_bytes.size() == 0) msg_bytes.push_back(pick_letter());
  endfunction

  initial begin
    int start;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // negative id with leading tab, empty type, empty data field stops the scan,
    // then a terminator and a top-range byte that must be ignored
    put_text("#\t-3#$$&9&&");
    msg_bytes.push_back(CH_NUL);
    msg_bytes.push_back(8'hFF);
    send_message();
    // seven data fields into six slots
    put_text("&1&2&3&4&5&6&7&");
    send_message();
    // a lone terminator as the whole message
    msg_bytes.push_back(CH_NUL);
    send_message();
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
          // receiver holds off while words keep coming, so the unit backs up
          hold_asks <= hold_asks + 1;
        end
        1: begin
          idle_pct = 88;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 88;
        end
        default: begin
          idle_pct = 8;
          stall_pct <= 8;
        end
      endcase
      start = words_sent;
      while (words_sent - start < RANDOM_WORDS / 4) begin
        build_message();
        send_message();
      end
      drain();
    end

    repeat (4) @(posedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
